// ===== rtl/lpf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED PWM fader package
// Constants, types and fade state codes shared by the LED PWM fader.
// ----------------------------------------------------------------------------
package lpf_pkg;

	localparam int NUM_LEDS        = 10;
	localparam int SLOTS_PER_FRAME = 255;

	localparam int LEVEL_W = 8;
	localparam int MASK_W  = 10;
	localparam int CNT_W   = (SLOTS_PER_FRAME > 2) ? $clog2(SLOTS_PER_FRAME) : 1;
	localparam int IN_W    = 16;
	localparam int OUT_W   = 16;

	typedef logic [LEVEL_W-1:0] level_t;
	typedef logic [CNT_W-1:0]   cnt_t;
	typedef logic [1:0]         fade_t;

	localparam level_t LEVEL_MAX = '1;

	localparam fade_t FADE_DEAD  = 2'd0;
	localparam fade_t FADE_ALIVE = 2'd1;
	localparam fade_t FADE_DYING = 2'd2;
	localparam fade_t FADE_BORN  = 2'd3;

endpackage

// ===== rtl/led_pwm_fader.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED PWM fader
// Slot-by-slot PWM driver for a row of LEDs with per-LED fade in and fade out.
// ----------------------------------------------------------------------------
// Each beat on the input stream is one PWM slot tick. The tick is taken into
// an input register, and from there all LEDs are compared with the
// shared slot counter in parallel, fades are stepped at a frame end and the
// optional target mask is applied. The new line pattern then goes to the
// result register once that register is free or is being emptied.
// Throughput is one beat per cycle unless the receiver stalls; every LED has
// its own comparator and fade logic; only the single slot counter is shared.
// A frame ends when the slot counter wraps; that result beat carries tlast.
// A paused tick holds the lines and the counter but still applies targets.
// Reset turns all lines off, zeroes every level and marks every LED dead.
// While the receiver stalls, the result register holds its beat and the input
// register can still take one more tick; only when both are full does
// s_axis_tready fall. No beat is ever dropped or repeated.
// ----------------------------------------------------------------------------
module led_pwm_fader (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     s_axis_tvalid,
	output logic                     s_axis_tready,
	// [9:0] target_on_mask, [10] pause, [15:11] zero
	input  logic [lpf_pkg::IN_W-1:0] s_axis_tdata,
	// [0] update_targets
	input  logic                     s_axis_tuser,
	output logic                     m_axis_tvalid,
	input  logic                     m_axis_tready,
	// [9:0] led_lines, [15:10] zero
	output logic [lpf_pkg::OUT_W-1:0] m_axis_tdata,
	// frame_done
	output logic                     m_axis_tlast
);

	// Input register stage.
	logic                       valid_s1;
	logic                       upd_s1;
	logic                       pause_s1;
	logic [lpf_pkg::MASK_W-1:0] mask_s1;

	// Block state.
	lpf_pkg::level_t             level_q [lpf_pkg::NUM_LEDS];
	lpf_pkg::fade_t              fade_q  [lpf_pkg::NUM_LEDS];
	lpf_pkg::cnt_t               cnt_q;
	logic [lpf_pkg::NUM_LEDS-1:0] lines_q;

	// Next-state values.
	lpf_pkg::level_t             level_d [lpf_pkg::NUM_LEDS];
	lpf_pkg::fade_t              fade_d  [lpf_pkg::NUM_LEDS];
	lpf_pkg::cnt_t               cnt_d;
	logic [lpf_pkg::NUM_LEDS-1:0] lines_d;
	logic [lpf_pkg::CNT_W:0]      cnt_inc;
	logic                         wrap;
	logic [lpf_pkg::NUM_LEDS-1:0] want_on;

	// Result register.
	logic                       m_valid_q;
	logic [lpf_pkg::MASK_W-1:0] m_lines_q;
	logic                       m_last_q;

	logic adv;

	// The tick in the input register moves on whenever the result register is
	// free or is being emptied in this cycle.
	assign adv           = valid_s1 && (!m_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			mask_s1  <= s_axis_tdata[lpf_pkg::MASK_W-1:0];
			pause_s1 <= s_axis_tdata[lpf_pkg::MASK_W];
			upd_s1   <= s_axis_tuser;
		end
	end

	// Mask bits for LEDs beyond the mask width read as fade out.
	assign want_on = lpf_pkg::NUM_LEDS'(mask_s1);

	always_comb begin
		cnt_inc = {1'b0, cnt_q} + 1'b1;
		wrap    = !pause_s1 && (cnt_inc >= (lpf_pkg::CNT_W + 1)'(lpf_pkg::SLOTS_PER_FRAME));
		if (pause_s1) begin
			cnt_d = cnt_q;
		end else if (wrap) begin
			cnt_d = '0;
		end else begin
			cnt_d = cnt_inc[lpf_pkg::CNT_W-1:0];
		end

		for (int i = 0; i < lpf_pkg::NUM_LEDS; i++) begin
			lines_d[i] = lines_q[i];
			level_d[i] = level_q[i];
			fade_d[i]  = fade_q[i];

			if (!pause_s1) begin
				lines_d[i] = (level_q[i] != '0) &&
					(level_q[i] >= lpf_pkg::LEVEL_W'(cnt_q));
			end

			// Frame end: dead and alive LEDs are forced off and on, fading
			// LEDs step one level and settle when they reach the end.
			if (wrap) begin
				case (fade_q[i])
					lpf_pkg::FADE_DEAD: begin
						lines_d[i] = 1'b0;
					end
					lpf_pkg::FADE_ALIVE: begin
						lines_d[i] = 1'b1;
					end
					lpf_pkg::FADE_DYING: begin
						if (level_q[i] == '0) begin
							fade_d[i] = lpf_pkg::FADE_DEAD;
						end else begin
							level_d[i] = level_q[i] - 1'b1;
						end
					end
					lpf_pkg::FADE_BORN: begin
						if (level_q[i] == lpf_pkg::LEVEL_MAX) begin
							fade_d[i] = lpf_pkg::FADE_ALIVE;
						end else begin
							level_d[i] = level_q[i] + 1'b1;
						end
					end
					default: begin
						fade_d[i] = fade_q[i];
					end
				endcase
			end

			// New targets act on the state left by the frame end.
			if (upd_s1) begin
				if (want_on[i]) begin
					if (fade_d[i] != lpf_pkg::FADE_ALIVE) begin
						fade_d[i] = lpf_pkg::FADE_BORN;
					end
				end else begin
					if (fade_d[i] != lpf_pkg::FADE_DEAD) begin
						fade_d[i] = lpf_pkg::FADE_DYING;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			lines_q <= '0;
			for (int i = 0; i < lpf_pkg::NUM_LEDS; i++) begin
				level_q[i] <= '0;
				fade_q[i]  <= lpf_pkg::FADE_DEAD;
			end
		end else if (adv) begin
			cnt_q   <= cnt_d;
			lines_q <= lines_d;
			for (int i = 0; i < lpf_pkg::NUM_LEDS; i++) begin
				level_q[i] <= level_d[i];
				fade_q[i]  <= fade_d[i];
			end
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (adv) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			m_lines_q <= lpf_pkg::MASK_W'(lines_d);
			m_last_q  <= wrap;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = lpf_pkg::OUT_W'(m_lines_q);
	assign m_axis_tlast  = m_last_q;

	// A tick that reaches the last slot of a frame must produce a frame end.
	assert property (@(posedge clk) disable iff (!arst_n)
		(adv && !pause_s1 &&
			(cnt_q == lpf_pkg::CNT_W'(lpf_pkg::SLOTS_PER_FRAME - 1)))
		|=> (m_axis_tlast && cnt_q == '0))
		else $error("slot counter did not wrap at the end of a frame");

	// The slot counter never leaves its frame.
	assert property (@(posedge clk) disable iff (!arst_n)
		({1'b0, cnt_q} < (lpf_pkg::CNT_W + 1)'(lpf_pkg::SLOTS_PER_FRAME)))
		else $error("slot counter out of range");

	// A paused tick leaves the counter and the lines as they were.
	assert property (@(posedge clk) disable iff (!arst_n)
		(adv && pause_s1) |=> ($stable(cnt_q) && $stable(lines_q) && !m_axis_tlast))
		else $error("paused tick changed the counter or the lines");

	// A stalled result beat is not overwritten by a tick from the input stage.
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_valid_q && !m_axis_tready) |-> !adv)
		else $error("result register overwritten while stalled");

endmodule

// ===== tb/led_pwm_fader_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED PWM fader testbench
// Drives PWM slot ticks into the fader and checks every line pattern and
// frame marker against a cycle-free model of the LED levels and fade states.
// ----------------------------------------------------------------------------
// A short directed run covers the target mask extremes, paused ticks and
// requests on dead LEDs. A gapless fade run then brings every LED up for a
// frame and fades them out again in a staggered way, so that some LEDs reach
// zero and die while the others are still stepping down. A back-pressure run
// stalls the result side long enough to fill the block, and a random run
// mixes pauses, target updates and idle cycles on both sides.
// ----------------------------------------------------------------------------
module led_pwm_fader_tb;

	typedef struct packed {
		logic [lpf_pkg::MASK_W-1:0] lines;
		logic                       frame_done;
	} slot_result_t;

	logic                          clk = 1'b0;
	logic                          arst_n;
	logic                          s_axis_tvalid;
	logic                          s_axis_tready;
	// [9:0] target_on_mask, [10] pause, [15:11] zero
	logic [lpf_pkg::IN_W-1:0]      s_axis_tdata;
	// [0] update_targets
	logic                          s_axis_tuser;
	logic                          m_axis_tvalid;
	logic                          m_axis_tready;
	// [9:0] led_lines, [15:10] zero
	logic [lpf_pkg::OUT_W-1:0]     m_axis_tdata;
	// frame_done
	logic                          m_axis_tlast;

	// Model of the block's state, advanced once per accepted tick.
	lpf_pkg::level_t               led_lvl [lpf_pkg::NUM_LEDS];
	lpf_pkg::fade_t                led_fade [lpf_pkg::NUM_LEDS];
	lpf_pkg::cnt_t                 slot_pos;
	logic [lpf_pkg::NUM_LEDS-1:0]  line_bits;

	slot_result_t                  expected_slots [$];
	int                            error_count = 0;

	// Idle control shared between the tests and the two stream sides.
	bit                            sender_idle = 1'b1;
	bit                            sink_idle   = 1'b1;
	int                            sink_hold   = 0;

	led_pwm_fader DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Works out the line pattern and frame marker that one accepted tick
	// produces, and queues them for the result side.
	task automatic advance_slot(input logic upd, input logic [lpf_pkg::MASK_W-1:0] mask,
			input logic pz);
		slot_result_t r;
		r.frame_done = 1'b0;
		if (!pz) begin
			for (int i = 0; i < lpf_pkg::NUM_LEDS; i++)
				line_bits[i] = (led_lvl[i] != '0) && (led_lvl[i] >= slot_pos);
			if (int'(slot_pos) + 1 >= lpf_pkg::SLOTS_PER_FRAME) begin
				// Frame end: fades step by one level, settled LEDs are forced.
				slot_pos = '0;
				r.frame_done = 1'b1;
				for (int i = 0; i < lpf_pkg::NUM_LEDS; i++) begin
					case (led_fade[i])
						lpf_pkg::FADE_DEAD:  line_bits[i] = 1'b0;
						lpf_pkg::FADE_ALIVE: line_bits[i] = 1'b1;
						lpf_pkg::FADE_DYING: begin
							if (led_lvl[i] == '0)
								led_fade[i] = lpf_pkg::FADE_DEAD;
							else
								led_lvl[i] = led_lvl[i] - 1'b1;
						end
						default: begin
							if (led_lvl[i] == lpf_pkg::LEVEL_MAX)
								led_fade[i] = lpf_pkg::FADE_ALIVE;
							else
								led_lvl[i] = led_lvl[i] + 1'b1;
						end
					endcase
				end
			end else begin
				slot_pos = slot_pos + 1'b1;
			end
		end
		// Targets are applied after the slot work, paused or not.
		if (upd) begin
			for (int i = 0; i < lpf_pkg::NUM_LEDS; i++) begin
				if (mask[i]) begin
					if (led_fade[i] != lpf_pkg::FADE_ALIVE)
						led_fade[i] = lpf_pkg::FADE_BORN;
				end else if (led_fade[i] != lpf_pkg::FADE_DEAD) begin
					led_fade[i] = lpf_pkg::FADE_DYING;
				end
			end
		end
		r.lines = line_bits[lpf_pkg::MASK_W-1:0];
		expected_slots.push_back(r);
	endtask

	// Offers one tick and returns at the edge where it is accepted. The valid
	// stays high so that a following tick can go out in the very next cycle.
	task automatic send_tick(input logic upd, input logic [lpf_pkg::MASK_W-1:0] mask,
			input logic pz);
		int gap;
		gap = sender_idle ? int'($urandom_range(0, 6)) : 0;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {{(lpf_pkg::IN_W - lpf_pkg::MASK_W - 1){1'b0}}, pz, mask};
		s_axis_tuser  <= upd;
		do
			@(posedge clk);
		while (s_axis_tready !== 1'b1);
		advance_slot(upd, mask, pz);
	endtask

	// Withdraws the sender and waits until every queued result has arrived.
	task automatic hold_until_drained();
		s_axis_tvalid <= 1'b0;
		while (expected_slots.size() != 0)
			@(posedge clk);
	endtask

	// Result side: a random stall before each beat while idling is on, or a long
	// hold-off when a test asks for one, then the beat is taken and checked.
	always begin : result_sink
		int           stall;
		slot_result_t want;
		stall = sink_idle ? int'($urandom_range(0, 6)) : 0;
		if (sink_hold > 0) begin
			stall = sink_hold;
			sink_hold = 0;
		end
		if (stall > 0) begin
			m_axis_tready <= 1'b0;
			repeat (stall) @(posedge clk);
		end
		m_axis_tready <= 1'b1;
		do
			@(posedge clk);
		while (m_axis_tvalid !== 1'b1);
		if (expected_slots.size() == 0) begin
			$display("%0t: unexpected result beat, expected none, actual tdata %h tlast %b",
				$time, m_axis_tdata, m_axis_tlast);
			error_count++;
		end else begin
			want = expected_slots.pop_front();
			if (m_axis_tdata !== lpf_pkg::OUT_W'(want.lines)) begin
				$display("%0t: led_lines mismatch, expected %h actual %h",
					$time, lpf_pkg::OUT_W'(want.lines), m_axis_tdata);
				error_count++;
			end
			if (m_axis_tlast !== want.frame_done) begin
				$display("%0t: frame_done mismatch, expected %b actual %b",
					$time, want.frame_done, m_axis_tlast);
				error_count++;
			end
		end
	end

	// Mask extremes, single and alternating bits, paused ticks with and
	// without target updates, and fade requests on dead LEDs.
	task automatic test_directed_targets();
		send_tick(1'b1, 10'h000, 1'b0);
		send_tick(1'b0, 10'h000, 1'b0);
		send_tick(1'b1, 10'h3FF, 1'b0);
		send_tick(1'b0, 10'h3FF, 1'b1);
		send_tick(1'b1, 10'h000, 1'b1);
		send_tick(1'b1, 10'h3FF, 1'b1);
		send_tick(1'b1, 10'h155, 1'b0);
		send_tick(1'b1, 10'h2AA, 1'b0);
		send_tick(1'b1, 10'h001, 1'b0);
		send_tick(1'b1, 10'h200, 1'b0);
		send_tick(1'b0, 10'h155, 1'b0);
		send_tick(1'b0, 10'h2AA, 1'b1);
		send_tick(1'b1, 10'h000, 1'b0);
		send_tick(1'b1, 10'h3FF, 1'b0);
	endtask

	// Every LED fades in for one frame, then the fade-out is staggered: even
	// LEDs step down to zero and die, odd LEDs climb once more before they
	// start to fall, so the lines show a spread of levels.
	task automatic test_fade_in_out();
		logic [lpf_pkg::MASK_W-1:0] mask;
		sender_idle = 1'b0;
		sink_idle   = 1'b0;
		for (int s = 0; s < lpf_pkg::SLOTS_PER_FRAME; s++)
			send_tick(s == 0, '1, 1'b0);
		for (int f = 0; f < 2; f++) begin
			for (int i = 0; i < lpf_pkg::MASK_W; i++)
				mask[i] = f < (i % 2);
			for (int s = 0; s < lpf_pkg::SLOTS_PER_FRAME; s++)
				send_tick(s == 0, mask, 1'b0);
		end
		sender_idle = 1'b1;
		sink_idle   = 1'b1;
	endtask

	// The result side holds off for a long stretch while ticks keep coming,
	// so the block fills and stalls its input; then the sender waits for the
	// block to empty before a short run with gaps.
	task automatic test_backpressure();
		sender_idle = 1'b0;
		sink_hold   = 40;
		for (int k = 0; k < 30; k++)
			send_tick(1'($urandom_range(0, 1)), 10'($urandom_range(0, 1023)),
				1'($urandom_range(0, 1)));
		hold_until_drained();
		sender_idle = 1'b1;
		for (int k = 0; k < 10; k++)
			send_tick(1'($urandom_range(0, 1)), 10'($urandom_range(0, 1023)),
				1'($urandom_range(0, 1)));
		hold_until_drained();
	endtask

	// Mostly running ticks so that frames keep ending, with occasional pauses
	// and target updates; idling is switched off for part of every stretch.
	task automatic test_random_ticks(input int count);
		for (int k = 0; k < count; k++) begin
			logic                       upd;
			logic [lpf_pkg::MASK_W-1:0] mask;
			logic                       pz;
			sender_idle = (k % 400) >= 60;
			sink_idle   = (k % 400) < 300 || (k % 400) >= 340;
			upd  = $urandom_range(0, 31) == 0;
			mask = 10'($urandom_range(0, 1023));
			pz   = $urandom_range(0, 7) == 0;
			send_tick(upd, mask, pz);
		end
		sender_idle = 1'b1;
		sink_idle   = 1'b1;
	endtask

	initial begin
		arst_n        <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		s_axis_tuser  <= 1'b0;
		for (int i = 0; i < lpf_pkg::NUM_LEDS; i++) begin
			led_lvl[i]  = '0;
			led_fade[i] = lpf_pkg::FADE_DEAD;
		end
		slot_pos  = '0;
		line_bits = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_targets();
		test_fade_in_out();
		test_backpressure();
		test_random_ticks(800);
		hold_until_drained();
		repeat (8) @(posedge clk);
		if (error_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	// Generous bound: the slowest correct run takes well under a fifth of it.
	initial begin
		#20000000;
		$display("simulation failed");
		$finish;
	end

endmodule
